// ===== rtl/perspective_project_to_screen_unit_defines.svh =====
// Assertion macros for the perspective projection unit
`ifndef PERSPECTIVE_PROJECT_TO_SCREEN_UNIT_DEFINES_SVH
`define PERSPECTIVE_PROJECT_TO_SCREEN_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define PPSU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppsu assertion failed");

// next-cycle implication, clocked on clk, off during rst
`define PPSU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppsu assertion failed");

`endif

// ===== rtl/ppsu_pkg.sv =====
// Shared types, constants and helpers of the perspective projection unit
`default_nettype none
package ppsu_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COEF_W          = 32;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 4;
  localparam int VP_W            = 26;
  localparam int SIZE_W          = 13;
  localparam int OUT_W           = 16;
  localparam int W_MIN_Q16       = 66;   // ceil(0.001 * 2^16)
  localparam int DIV_STEPS       = 16;
  localparam int DOT_LAT         = 2;
  localparam int LANE_LAT        = DIV_STEPS + 3;
  localparam int TOTAL_LAT       = DOT_LAT + 1 + LANE_LAT + 1;

  localparam logic [VP_W-1:0] VP_RESET = 26'd15729720;   // 1920 x 1080

  localparam logic [CFG_IDX_W-1:0] REG_ROW0_01 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_23 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_01 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_23 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_01 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_23 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LOADED   = 4'd7;

  localparam logic signed [OUT_W-1:0] SAT_POS = 16'sh7fff;
  localparam logic signed [OUT_W-1:0] SAT_NEG = 16'sh8000;
  localparam logic signed [OUT_W-1:0] OFF_VAL = -16'sd1;

  typedef struct packed {
    logic signed [COEF_W-1:0] c0;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c3;
  } coef_row_t;

  // width of a dot product sum in Q.16
  function automatic int dot_width(input int cw);
    return cw + 12;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ppsu_if.sv =====
// Channel interfaces: point input, screen result, configuration write
`default_nettype none
interface ppsu_pt_if import ppsu_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface ppsu_res_if import ppsu_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] screen_x;
  logic signed [OUT_W-1:0] screen_y;
  logic                    visible;
  modport source (output valid, screen_x, screen_y, visible, input ready);
  modport sink   (input valid, screen_x, screen_y, visible, output ready);
endinterface

interface ppsu_cfg_if import ppsu_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/perspective_project_to_screen_unit.sv =====
// Top level: configuration registers, projection pipeline, result register
//
// Projects one world point per clock to viewport pixels. An accepted point
// reaches the result channel through the multiply and sum registers of the
// three row dot products, the clip offset register, each of the two scale
// lanes (the size product, the range check and sixteen one-bit restoring
// division steps), and the result register. Throughput is one word per cycle;
// a stall on the result channel freezes the whole pipeline. Configuration
// writes are taken every cycle and must be made while no point is in flight.
`default_nettype none
`include "perspective_project_to_screen_unit_defines.svh"
module perspective_project_to_screen_unit import ppsu_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ppsu_cfg_if.sink   cfg,
  ppsu_pt_if.sink    pt,
  ppsu_res_if.source res
);
  localparam int SW = dot_width(COORD_WIDTH);
  localparam int MW = SW + 1;

  logic [CFG_DATA_W-1:0] coef [6];
  logic [VP_W-1:0]       viewport;
  logic                  loaded;

  coef_row_t row0, row1, row3;
  logic signed [SW-1:0] cx, cy, w;
  logic signed [SW:0]   tx, ty;
  logic [MW-1:0]        mag_x, mag_y;
  logic                 neg_x, neg_y, behind;
  logic [SW-1:0]        dq;
  logic [LANE_LAT-1:0]  bdly;
  logic [TOTAL_LAT-1:0] vld;
  logic signed [OUT_W-1:0] lane_x, lane_y;
  logic                 en;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        coef[i] <= '0;
      end
      viewport <= VP_RESET;
      loaded   <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ROW0_01:  coef[0] <= cfg.data;
        REG_ROW0_23:  coef[1] <= cfg.data;
        REG_ROW1_01:  coef[2] <= cfg.data;
        REG_ROW1_23:  coef[3] <= cfg.data;
        REG_ROW3_01:  coef[4] <= cfg.data;
        REG_ROW3_23:  coef[5] <= cfg.data;
        REG_VIEWPORT: viewport <= cfg.data[VP_W-1:0];
        REG_LOADED:   loaded <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign row0 = '{c0: coef[0][63:32], c1: coef[0][31:0],
                  c2: coef[1][63:32], c3: coef[1][31:0]};
  assign row1 = '{c0: coef[2][63:32], c1: coef[2][31:0],
                  c2: coef[3][63:32], c3: coef[3][31:0]};
  assign row3 = '{c0: coef[4][63:32], c1: coef[4][31:0],
                  c2: coef[5][63:32], c3: coef[5][31:0]};

  // whole pipeline advances together
  assign en       = !vld[TOTAL_LAT-1] || res.ready;
  assign pt.ready = en;
  assign res.valid = vld[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL_LAT-2:0], pt.valid};
    end
  end

  ppsu_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot0 (
    .clk(clk), .en(en), .row(row0),
    .px(pt.pos_x), .py(pt.pos_y), .pz(pt.pos_z), .dot(cx)
  );
  ppsu_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot1 (
    .clk(clk), .en(en), .row(row1),
    .px(pt.pos_x), .py(pt.pos_y), .pz(pt.pos_z), .dot(cy)
  );
  ppsu_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot3 (
    .clk(clk), .en(en), .row(row3),
    .px(pt.pos_x), .py(pt.pos_y), .pz(pt.pos_z), .dot(w)
  );

  assign tx = (SW+1)'(w) + (SW+1)'(cx);
  assign ty = (SW+1)'(w) - (SW+1)'(cy);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_x  <= tx[SW];
      neg_y  <= ty[SW];
      mag_x  <= tx[SW] ? MW'(-tx) : MW'(tx);
      mag_y  <= ty[SW] ? MW'(-ty) : MW'(ty);
      dq     <= {w[SW-2:0], 1'b0};
      behind <= w < W_MIN_Q16;
    end
  end

  ppsu_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale_x (
    .clk(clk), .en(en), .size(viewport[VP_W-1:SIZE_W]),
    .mag(mag_x), .neg(neg_x), .d(dq), .scaled(lane_x)
  );
  ppsu_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale_y (
    .clk(clk), .en(en), .size(viewport[SIZE_W-1:0]),
    .mag(mag_y), .neg(neg_y), .d(dq), .scaled(lane_y)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      bdly <= {bdly[LANE_LAT-2:0], behind};
      if (!loaded) begin
        res.screen_x <= '0;
        res.screen_y <= '0;
        res.visible  <= 1'b0;
      end else if (bdly[LANE_LAT-1]) begin
        res.screen_x <= OFF_VAL;
        res.screen_y <= OFF_VAL;
        res.visible  <= 1'b0;
      end else begin
        res.screen_x <= lane_x;
        res.screen_y <= lane_y;
        res.visible  <= 1'b1;
      end
    end
  end

  // off-screen words carry (0,0) or (-1,-1) only
  `PPSU_ASSERT_IMP(a_offscreen_code, res.valid && !res.visible, (res.screen_x == res.screen_y) && ((res.screen_x == '0) || (res.screen_x == OFF_VAL)))
  // a stall freezes every stage's valid bit
  `PPSU_ASSERT_NXT(a_stall_holds, !en, $stable(vld))

endmodule
`default_nettype wire

// ===== rtl/ppsu_dot.sv =====
// Two-stage dot product of one matrix row with a point, floored to Q.16
`default_nettype none
module ppsu_dot import ppsu_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  coef_row_t                                 row,
  input  logic signed [COORD_WIDTH-1:0]             px,
  input  logic signed [COORD_WIDTH-1:0]             py,
  input  logic signed [COORD_WIDTH-1:0]             pz,
  output logic signed [dot_width(COORD_WIDTH)-1:0]  dot
);
  localparam int PHW = COORD_WIDTH - 15;
  localparam int PW  = COEF_W + PHW;
  localparam int BW  = COEF_W + 17;
  localparam int AW  = PW + 17;
  localparam int TW  = AW - 24;
  localparam int SW  = dot_width(COORD_WIDTH);
  localparam int C3W = COEF_W - 8;

  logic signed [COORD_WIDTH-1:0] p [3];
  logic signed [COEF_W-1:0]      c [3];
  logic signed [PW-1:0]          a [3];
  logic signed [BW-1:0]          b [3];
  logic signed [TW-1:0]          t [3];
  logic signed [C3W-1:0]         c3s;

  assign p[0] = px;
  assign p[1] = py;
  assign p[2] = pz;
  assign c[0] = row.c0;
  assign c[1] = row.c1;
  assign c[2] = row.c2;

  for (genvar k = 0; k < 3; k++) begin : g_term
    logic signed [PHW-1:0] ph;
    logic signed [AW-1:0]  s;
    // point split as ph * 2^16 + pl keeps each product near 32 x 17
    assign ph = PHW'(p[k] >>> 16);
    always_ff @(posedge clk) begin
      if (en) begin
        a[k] <= c[k] * ph;
        b[k] <= c[k] * $signed({1'b0, p[k][15:0]});
      end
    end
    assign s    = (AW'(a[k]) <<< 16) + AW'(b[k]);
    assign t[k] = TW'(s >>> 24);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3s <= C3W'(row.c3 >>> 8);
      dot <= SW'(t[0]) + SW'(t[1]) + SW'(t[2]) + SW'(c3s);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ppsu_scale.sv =====
// Viewport scale lane: size * mag / d, restoring division, saturated to 16 bits
`default_nettype none
module ppsu_scale import ppsu_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [SIZE_W-1:0]                     size,
  input  logic [dot_width(COORD_WIDTH):0]       mag,
  input  logic                                  neg,
  input  logic [dot_width(COORD_WIDTH)-1:0]     d,
  output logic signed [OUT_W-1:0]               scaled
);
  localparam int DW   = dot_width(COORD_WIDTH);
  localparam int MW   = DW + 1;
  localparam int H    = (MW + 1) / 2;
  localparam int HI_W = MW - H;
  localparam int NW   = MW + SIZE_W;
  localparam int RW   = DW + 17;

  logic [SIZE_W+H-1:0]    plo;
  logic [SIZE_W+HI_W-1:0] phi;
  logic [DW-1:0]          d1, d2;
  logic                   neg1, neg2;
  logic [NW-1:0]          nval;

  logic [RW-1:0]    rem [DIV_STEPS+1];
  logic [OUT_W-1:0] quo [DIV_STEPS+1];
  logic [DW-1:0]    dd  [DIV_STEPS+1];
  logic             ov  [DIV_STEPS+1];
  logic             ng  [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      plo    <= size * mag[H-1:0];
      phi    <= size * mag[MW-1:H];
      d1     <= d;
      neg1   <= neg;
      nval   <= (NW'(phi) << H) + NW'(plo);
      d2     <= d1;
      neg2   <= neg1;
      rem[0] <= RW'(nval);
      ov[0]  <= RW'(nval) >= (RW'(d2) << DIV_STEPS);
      quo[0] <= '0;
      dd[0]  <= d2;
      ng[0]  <= neg2;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int SH = DIV_STEPS - 1 - k;
    logic [RW-1:0] dk;
    logic          ge;
    assign dk = RW'(dd[k]) << SH;
    assign ge = rem[k] >= dk;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - dk : rem[k];
        quo[k+1] <= quo[k] | (OUT_W'(ge) << SH);
        dd[k+1]  <= dd[k];
        ov[k+1]  <= ov[k];
        ng[k+1]  <= ng[k];
      end
    end
  end

  always_comb begin
    if (size == '0) begin
      scaled = '0;
    end else if (ng[DIV_STEPS]) begin
      if (ov[DIV_STEPS] || quo[DIV_STEPS] > 16'h8000) begin
        scaled = SAT_NEG;
      end else begin
        scaled = OUT_W'(-quo[DIV_STEPS]);
      end
    end else begin
      if (ov[DIV_STEPS] || quo[DIV_STEPS][OUT_W-1]) begin
        scaled = SAT_POS;
      end else begin
        scaled = quo[DIV_STEPS];
      end
    end
  end
endmodule
`default_nettype wire
